// ===== rtl/ll2mm_pkg.sv =====
// Shared types, constants and the CORDIC arctangent table for latlon_to_local_mm.
package ll2mm_pkg;

    // Port field widths
    localparam int LAT_W   = 31;
    localparam int LON_W   = 32;
    localparam int NORTH_W = 35;
    localparam int EAST_W  = 36;

    // Magnitudes after saturation
    localparam int ALAT_W = 30;
    localparam int ALON_W = 32;
    localparam logic signed [LAT_W-1:0] LAT_LIMIT = 31'sd900000000;

    // Angle in Q30 radians: (alat * ANG_SCALE) >> 32
    localparam int ANG_W = 31;
    localparam logic [32:0] ANG_SCALE = 33'd8048910509;

    // CORDIC
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int CORDIC_MAX        = 32;
    localparam int CW                = 33;
    localparam logic signed [CW-1:0] INV_GAIN = 33'sd652032874;
    localparam logic signed [CW-1:0] ONE_Q30  = 33'sd1073741824;
    localparam int C_W               = 31;

    // North path: alat*11 + floor(alat*NP_MUL / 1e10)
    localparam int NP_W  = 60;
    localparam int A11_W = 34;
    localparam logic [30:0] NP_MUL   = 31'd1132952548;
    localparam logic [3:0]  NORTH_INT = 4'd11;
    localparam int NORTH_SHIFT = 10;
    localparam int NORTH_N_W   = NP_W - NORTH_SHIFT;
    localparam int NORTH_DIV_W = 24;
    localparam logic [63:0] NORTH_DIV = 64'd9765625;
    localparam logic signed [NORTH_W-1:0] NORTH_MAX = 35'sd10001965730;

    // Scale polynomial coefficients
    localparam logic [26:0] SCALE_C1 = 27'd111412840;
    localparam logic [16:0] SCALE_C3 = 17'd93500;
    localparam logic [6:0]  SCALE_C5 = 7'd118;
    localparam int M_W = 57;

    // East path: floor(floor(alon*m / 2^30) / 1e7)
    localparam int T_W        = 59;
    localparam int EAST_SHIFT = 7;
    localparam int EAST_N_W   = T_W - EAST_SHIFT;
    localparam int EAST_DIV_W = 17;
    localparam logic [63:0] EAST_DIV = 64'd78125;

    typedef struct packed {
        logic en;
        logic valid;
    } t_stage_ctl;

    typedef struct packed {
        logic [NP_W-1:0]   np;
        logic [A11_W-1:0]  alat11;
        logic [ALON_W-1:0] alon;
        logic              lat_neg;
        logic              lon_neg;
    } t_side;

    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] v;
        unique case (idx)
            5'd0:  v = 30'd843314857;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043837;
            5'd3:  v = 30'd133525159;
            5'd4:  v = 30'd67021687;
            5'd5:  v = 30'd33543516;
            5'd6:  v = 30'd16775851;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194283;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048576;
            5'd11: v = 30'd524288;
            5'd12: v = 30'd262144;
            5'd13: v = 30'd131072;
            5'd14: v = 30'd65536;
            5'd15: v = 30'd32768;
            5'd16: v = 30'd16384;
            5'd17: v = 30'd8192;
            5'd18: v = 30'd4096;
            5'd19: v = 30'd2048;
            5'd20: v = 30'd1024;
            5'd21: v = 30'd512;
            5'd22: v = 30'd256;
            5'd23: v = 30'd128;
            5'd24: v = 30'd64;
            5'd25: v = 30'd32;
            5'd26: v = 30'd16;
            5'd27: v = 30'd8;
            5'd28: v = 30'd4;
            5'd29: v = 30'd2;
            5'd30: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/ll2mm_in_if.sv =====
// Request channel carrying one latitude/longitude pair.
interface ll2mm_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [ll2mm_pkg::LAT_W-1:0] latitude_e7;
    logic signed [ll2mm_pkg::LON_W-1:0] longitude_e7;

    modport source (output valid, latitude_e7, longitude_e7, input ready);
    modport sink   (input valid, latitude_e7, longitude_e7, output ready);
endinterface

// ===== rtl/ll2mm_out_if.sv =====
// Result channel carrying one north/east offset pair.
interface ll2mm_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [ll2mm_pkg::NORTH_W-1:0] north_mm;
    logic signed [ll2mm_pkg::EAST_W-1:0]  east_mm;

    modport source (output valid, north_mm, east_mm, input ready);
    modport sink   (input valid, north_mm, east_mm, output ready);
endinterface

// ===== rtl/ll2mm_cordic.sv =====
// Pipelined rotation-mode CORDIC giving cos of a Q30 angle, one stage per register.
module ll2mm_cordic #(
    parameter int STAGES = ll2mm_pkg::CORDIC_STAGES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ll2mm_pkg::t_stage_ctl              i_ctl,
    input  logic [ll2mm_pkg::ANG_W-1:0]        i_angle,
    input  ll2mm_pkg::t_side                   i_side,
    output logic                               o_valid,
    output logic [ll2mm_pkg::C_W-1:0]          o_cos,
    output ll2mm_pkg::t_side                   o_side
);
    localparam int CW = ll2mm_pkg::CW;

    logic signed [CW-1:0] s_x [0:STAGES];
    logic signed [CW-1:0] s_y [0:STAGES];
    logic signed [CW-1:0] s_z [0:STAGES];
    logic                 s_v [0:STAGES];
    ll2mm_pkg::t_side     s_sb[0:STAGES];

    assign s_x[0]  = ll2mm_pkg::INV_GAIN;
    assign s_y[0]  = '0;
    assign s_z[0]  = $signed({2'b00, i_angle});
    assign s_v[0]  = i_ctl.valid;
    assign s_sb[0] = i_side;

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        logic signed [CW-1:0] r_x, r_y, r_z;
        logic signed [CW-1:0] n_x, n_y, n_z;
        logic signed [CW-1:0] w_dx, w_dy, w_at;
        logic                 r_v;
        ll2mm_pkg::t_side     r_sb;

        assign w_dx = s_y[i] >>> i;
        assign w_dy = s_x[i] >>> i;
        assign w_at = $signed({3'b000, ll2mm_pkg::atan_q30(5'(i))});

        always_comb begin
            if (!s_z[i][CW-1]) begin
                n_x = s_x[i] - w_dx;
                n_y = s_y[i] + w_dy;
                n_z = s_z[i] - w_at;
            end else begin
                n_x = s_x[i] + w_dx;
                n_y = s_y[i] - w_dy;
                n_z = s_z[i] + w_at;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_ctl.en) begin
                r_v <= s_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_x  <= n_x;
                r_y  <= n_y;
                r_z  <= n_z;
                r_sb <= s_sb[i];
            end
        end

        assign s_x[i+1]  = r_x;
        assign s_y[i+1]  = r_y;
        assign s_z[i+1]  = r_z;
        assign s_v[i+1]  = r_v;
        assign s_sb[i+1] = r_sb;
    end

    // clamp to [0, 1.0]
    always_comb begin
        if (s_x[STAGES][CW-1]) begin
            o_cos = '0;
        end else if (s_x[STAGES] > ll2mm_pkg::ONE_Q30) begin
            o_cos = ll2mm_pkg::C_W'(ll2mm_pkg::ONE_Q30);
        end else begin
            o_cos = s_x[STAGES][ll2mm_pkg::C_W-1:0];
        end
    end

    assign o_valid = s_v[STAGES];
    assign o_side  = s_sb[STAGES];
endmodule

// ===== rtl/ll2mm_scale.sv =====
// Powers of cos, Chebyshev multiple angles and the mm-per-degree scale, five stages.
module ll2mm_scale (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ll2mm_pkg::t_stage_ctl         i_ctl,
    input  logic [ll2mm_pkg::C_W-1:0]     i_cos,
    input  ll2mm_pkg::t_side              i_side,
    output logic                          o_valid,
    output logic [ll2mm_pkg::M_W-1:0]     o_m,
    output ll2mm_pkg::t_side              o_side
);
    localparam int C_W = ll2mm_pkg::C_W;

    logic [4:0]           r_v;
    ll2mm_pkg::t_side     r_sb [0:4];

    logic [C_W-1:0]       r1_c, r1_c2;
    logic [C_W-1:0]       r2_c, r2_c2, r2_c3;
    logic [C_W-1:0]       r3_c, r3_c3, r3_c5;
    logic [57:0]          r4_a;
    logic signed [52:0]   r4_b;
    logic signed [44:0]   r4_d;
    logic [ll2mm_pkg::M_W-1:0] r5_m;

    logic [61:0]          w_sq, w_cu, w_c5;
    logic signed [34:0]   w_cos3;
    logic signed [36:0]   w_cos5;
    logic [57:0]          w_a;
    logic signed [52:0]   w_b;
    logic signed [44:0]   w_d;
    logic signed [59:0]   w_s;

    assign w_sq = 62'(i_cos) * 62'(i_cos);
    assign w_cu = 62'(r1_c2) * 62'(r1_c);
    assign w_c5 = 62'(r2_c3) * 62'(r2_c2);

    assign w_cos3 = $signed({2'b00, r3_c3, 2'b00}) - $signed({3'b000, r3_c, 1'b0})
                  - $signed({4'b0000, r3_c});
    assign w_cos5 = $signed({2'b00, r3_c5, 4'b0000}) - $signed({2'b00, r3_c3, 4'b0000})
                  - $signed({4'b0000, r3_c3, 2'b00}) + $signed({4'b0000, r3_c, 2'b00})
                  + $signed({6'b000000, r3_c});

    assign w_a = 58'(ll2mm_pkg::SCALE_C1) * 58'(r3_c);
    assign w_b = $signed(53'(ll2mm_pkg::SCALE_C3)) * 53'(w_cos3);
    assign w_d = $signed(45'(ll2mm_pkg::SCALE_C5)) * 45'(w_cos5);

    assign w_s = $signed({2'b00, r4_a}) - 60'(r4_b) + 60'(r4_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_ctl.en) begin
            r_v <= {r_v[3:0], i_ctl.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_sb[0] <= i_side;
            r_sb[1] <= r_sb[0];
            r_sb[2] <= r_sb[1];
            r_sb[3] <= r_sb[2];
            r_sb[4] <= r_sb[3];

            r1_c  <= i_cos;
            r1_c2 <= w_sq[60:30];

            r2_c  <= r1_c;
            r2_c2 <= r1_c2;
            r2_c3 <= w_cu[60:30];

            r3_c  <= r2_c;
            r3_c3 <= r2_c3;
            r3_c5 <= w_c5[60:30];

            r4_a <= w_a;
            r4_b <= w_b;
            r4_d <= w_d;

            // clamp at zero from below
            r5_m <= w_s[59] ? '0 : w_s[ll2mm_pkg::M_W-1:0];
        end
    end

    assign o_valid = r_v[4];
    assign o_m     = r5_m;
    assign o_side  = r_sb[4];
endmodule

// ===== rtl/ll2mm_cdiv.sv =====
// Four-stage divide by a constant: reciprocal multiply, then one remainder correction.
module ll2mm_cdiv #(
    parameter int          NW   = 52,
    parameter int          DW   = 17,
    parameter logic [63:0] DIV  = 64'd78125,
    parameter int          SBW  = 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ll2mm_pkg::t_stage_ctl  i_ctl,
    input  logic [NW-1:0]          i_num,
    input  logic [SBW-1:0]         i_sb,
    output logic                   o_valid,
    output logic [NW-DW:0]         o_quo,
    output logic [SBW-1:0]         o_sb
);
    localparam int QW = NW - DW + 1;
    localparam int NL = NW / 2;
    localparam int NH = NW - NL;
    localparam int RL = QW / 2;
    localparam int RH = QW - RL;
    localparam int PW = NW + QW;
    localparam logic [QW-1:0] RCP  = QW'((64'd1 << NW) / DIV);
    localparam logic [DW:0]   DIVC = (DW + 1)'(DIV);

    logic [3:0]           r_v;
    logic [SBW-1:0]       r_sb [0:3];

    logic [NL+RL-1:0]     r1_ll;
    logic [NL+RH-1:0]     r1_lh;
    logic [NH+RL-1:0]     r1_hl;
    logic [NH+RH-1:0]     r1_hh;
    logic [DW:0]          r1_nlo, r2_nlo, r3_nlo;
    logic [QW-1:0]        r2_q, r3_q, r4_q;
    logic [DW:0]          r3_qd;

    logic [PW-1:0]        w_full;
    logic [DW:0]          w_rem;

    assign w_full = (PW'(r1_hh) << (NL + RL)) + (PW'(r1_hl) << NL)
                  + (PW'(r1_lh) << RL) + PW'(r1_ll);
    assign w_rem  = r3_nlo - r3_qd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_ctl.en) begin
            r_v <= {r_v[2:0], i_ctl.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_sb[0] <= i_sb;
            r_sb[1] <= r_sb[0];
            r_sb[2] <= r_sb[1];
            r_sb[3] <= r_sb[2];

            r1_ll  <= (NL + RL)'(i_num[NL-1:0]) * (NL + RL)'(RCP[RL-1:0]);
            r1_lh  <= (NL + RH)'(i_num[NL-1:0]) * (NL + RH)'(RCP[QW-1:RL]);
            r1_hl  <= (NH + RL)'(i_num[NW-1:NL]) * (NH + RL)'(RCP[RL-1:0]);
            r1_hh  <= (NH + RH)'(i_num[NW-1:NL]) * (NH + RH)'(RCP[QW-1:RL]);
            r1_nlo <= i_num[DW:0];

            // estimate is the quotient or one below it
            r2_q   <= w_full[PW-1:NW];
            r2_nlo <= r1_nlo;

            r3_q   <= r2_q;
            r3_qd  <= (DW + 1)'(r2_q[DW:0] * DIVC);
            r3_nlo <= r2_nlo;

            r4_q   <= r3_q + QW'(w_rem >= DIVC);
        end
    end

    assign o_valid = r_v[3];
    assign o_quo   = r4_q;
    assign o_sb    = r_sb[3];
endmodule

// ===== rtl/latlon_to_local_mm.sv =====
// Top level: latitude/longitude in 1e-7 degree to north/east offsets in millimetres.
//
// Takes one coordinate pair per clock and returns one north/east pair for each,
// in order. On the way from request to result a pair passes through one
// input register, one angle/product stage, CORDIC_STAGES rotation stages, five
// stages for the cosine powers and the scale, two for the longitude product,
// four for the constant dividers and one output register. The whole pipe moves
// together; it holds only while a finished result waits on a low ready, so the
// request side takes a new pair in every cycle that the result side drains.
// Latitude beyond +-90 degrees is saturated for both outputs; longitude is used
// as given. Both results are truncated toward zero and carry the input's sign.
module latlon_to_local_mm #(
    parameter int CORDIC_STAGES = ll2mm_pkg::CORDIC_STAGES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ll2mm_in_if.sink           i_req,
    ll2mm_out_if.source        o_rsp
);
    localparam int ALAT_W = ll2mm_pkg::ALAT_W;
    localparam int ALON_W = ll2mm_pkg::ALON_W;
    localparam int NQ_W   = ll2mm_pkg::NORTH_N_W - ll2mm_pkg::NORTH_DIV_W + 1;
    localparam int EQ_W   = ll2mm_pkg::EAST_N_W - ll2mm_pkg::EAST_DIV_W + 1;
    localparam int NSB_W  = ll2mm_pkg::A11_W + 1;

    // Advance everything unless a result is stuck at the output.
    logic w_en;
    logic r_out_valid;
    assign w_en        = !r_out_valid || o_rsp.ready;
    assign i_req.ready = w_en;

    // ---- request stage: saturate latitude, take magnitudes ----
    logic signed [ll2mm_pkg::LAT_W-1:0] w_lat_sat;
    logic                               w_lat_neg, w_lon_neg;
    logic [ALAT_W-1:0]                  w_alat;
    logic [ALON_W-1:0]                  w_alon;

    always_comb begin
        if (i_req.latitude_e7 > ll2mm_pkg::LAT_LIMIT) begin
            w_lat_sat = ll2mm_pkg::LAT_LIMIT;
        end else if (i_req.latitude_e7 < -ll2mm_pkg::LAT_LIMIT) begin
            w_lat_sat = -ll2mm_pkg::LAT_LIMIT;
        end else begin
            w_lat_sat = i_req.latitude_e7;
        end
    end

    assign w_lat_neg = i_req.latitude_e7[ll2mm_pkg::LAT_W-1];
    assign w_lon_neg = i_req.longitude_e7[ll2mm_pkg::LON_W-1];
    assign w_alat    = ALAT_W'(w_lat_neg ? -w_lat_sat : w_lat_sat);
    assign w_alon    = ALON_W'(w_lon_neg ? -i_req.longitude_e7 : i_req.longitude_e7);

    logic              r0_valid;
    logic [ALAT_W-1:0] r0_alat;
    logic [ALON_W-1:0] r0_alon;
    logic              r0_lat_neg, r0_lon_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (w_en) begin
            r0_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_alat    <= w_alat;
            r0_alon    <= w_alon;
            r0_lat_neg <= w_lat_neg;
            r0_lon_neg <= w_lon_neg;
        end
    end

    // ---- angle in Q30 radians and the north products ----
    logic [62:0]                    w_ang_prod;
    logic                           r1_valid;
    logic [ll2mm_pkg::ANG_W-1:0]    r1_angle;
    ll2mm_pkg::t_side               r1_side;

    assign w_ang_prod = 63'(r0_alat) * 63'(ll2mm_pkg::ANG_SCALE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid <= r0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_angle        <= w_ang_prod[62:32];
            r1_side.np      <= ll2mm_pkg::NP_W'(r0_alat) * ll2mm_pkg::NP_W'(ll2mm_pkg::NP_MUL);
            r1_side.alat11  <= ll2mm_pkg::A11_W'(r0_alat)
                             * ll2mm_pkg::A11_W'(ll2mm_pkg::NORTH_INT);
            r1_side.alon    <= r0_alon;
            r1_side.lat_neg <= r0_lat_neg;
            r1_side.lon_neg <= r0_lon_neg;
        end
    end

    // ---- cos of the latitude ----
    ll2mm_pkg::t_stage_ctl          w_cor_ctl;
    logic                           w_cor_valid;
    logic [ll2mm_pkg::C_W-1:0]      w_cos;
    ll2mm_pkg::t_side               w_cor_side;

    assign w_cor_ctl = '{en: w_en, valid: r1_valid};

    ll2mm_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_cor_ctl),
        .i_angle (r1_angle),
        .i_side  (r1_side),
        .o_valid (w_cor_valid),
        .o_cos   (w_cos),
        .o_side  (w_cor_side)
    );

    // ---- mm per degree of longitude, Q30 ----
    ll2mm_pkg::t_stage_ctl          w_scl_ctl;
    logic                           w_scl_valid;
    logic [ll2mm_pkg::M_W-1:0]      w_m;
    ll2mm_pkg::t_side               w_scl_side;

    assign w_scl_ctl = '{en: w_en, valid: w_cor_valid};

    ll2mm_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_scl_ctl),
        .i_cos   (w_cos),
        .i_side  (w_cor_side),
        .o_valid (w_scl_valid),
        .o_m     (w_m),
        .o_side  (w_scl_side)
    );

    // ---- floor(alon * m / 2^30), split on m at bit 32 ----
    logic                   r_t1_valid, r_t2_valid;
    logic [56:0]            r_t1_ph;
    logic [63:0]            r_t1_pl;
    ll2mm_pkg::t_side       r_t1_side, r_t2_side;
    logic [ll2mm_pkg::T_W-1:0] r_t2_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1_valid <= 1'b0;
            r_t2_valid <= 1'b0;
        end else if (w_en) begin
            r_t1_valid <= w_scl_valid;
            r_t2_valid <= r_t1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t1_ph   <= 57'(w_scl_side.alon) * 57'(w_m[ll2mm_pkg::M_W-1:32]);
            r_t1_pl   <= 64'(w_scl_side.alon) * 64'(w_m[31:0]);
            r_t1_side <= w_scl_side;
            r_t2_t    <= {r_t1_ph, 2'b00} + ll2mm_pkg::T_W'(r_t1_pl[63:30]);
            r_t2_side <= r_t1_side;
        end
    end

    // ---- divide by 1e10 (north) and 1e7 (east), low powers of two shifted out ----
    ll2mm_pkg::t_stage_ctl  w_div_ctl;
    logic                   w_nd_valid, w_ed_valid;
    logic [NQ_W-1:0]        w_nq;
    logic [EQ_W-1:0]        w_eq;
    logic [NSB_W-1:0]       w_nsb;
    logic                   w_esb;

    assign w_div_ctl = '{en: w_en, valid: r_t2_valid};

    ll2mm_cdiv #(
        .NW  (ll2mm_pkg::NORTH_N_W),
        .DW  (ll2mm_pkg::NORTH_DIV_W),
        .DIV (ll2mm_pkg::NORTH_DIV),
        .SBW (NSB_W)
    ) u_north_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_div_ctl),
        .i_num   (r_t2_side.np[ll2mm_pkg::NP_W-1:ll2mm_pkg::NORTH_SHIFT]),
        .i_sb    ({r_t2_side.alat11, r_t2_side.lat_neg}),
        .o_valid (w_nd_valid),
        .o_quo   (w_nq),
        .o_sb    (w_nsb)
    );

    ll2mm_cdiv #(
        .NW  (ll2mm_pkg::EAST_N_W),
        .DW  (ll2mm_pkg::EAST_DIV_W),
        .DIV (ll2mm_pkg::EAST_DIV),
        .SBW (1)
    ) u_east_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_div_ctl),
        .i_num   (r_t2_t[ll2mm_pkg::T_W-1:ll2mm_pkg::EAST_SHIFT]),
        .i_sb    (r_t2_side.lon_neg),
        .o_valid (w_ed_valid),
        .o_quo   (w_eq),
        .o_sb    (w_esb)
    );

    // ---- apply signs, output register ----
    logic [ll2mm_pkg::A11_W-1:0]          w_nmag;
    logic signed [ll2mm_pkg::NORTH_W-1:0] n_north, r_north;
    logic signed [ll2mm_pkg::EAST_W-1:0]  n_east, r_east;

    assign w_nmag  = w_nsb[NSB_W-1:1] + ll2mm_pkg::A11_W'(w_nq);
    assign n_north = w_nsb[0] ? -$signed(ll2mm_pkg::NORTH_W'(w_nmag))
                              : $signed(ll2mm_pkg::NORTH_W'(w_nmag));
    assign n_east  = w_esb ? -$signed(ll2mm_pkg::EAST_W'(w_eq))
                           : $signed(ll2mm_pkg::EAST_W'(w_eq));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_nd_valid && w_ed_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_north <= n_north;
            r_east  <= n_east;
        end
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.north_mm = r_north;
    assign o_rsp.east_mm  = r_east;
endmodule

// ===== rtl/ll2mm_checker.sv =====
// Port-level assertions for latlon_to_local_mm, attached by bind.
module ll2mm_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 i_in_ready,
    input logic                                 i_out_valid,
    input logic                                 i_out_ready,
    input logic signed [ll2mm_pkg::NORTH_W-1:0] i_north,
    input logic signed [ll2mm_pkg::EAST_W-1:0]  i_east
);
    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_north) && $stable(i_east))
        else $error("stalled result changed");

    // requests are taken whenever the result side is not blocked
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid || i_out_ready |-> i_in_ready)
        else $error("request refused while output free");

    // saturated latitude bounds the north offset, checked while a request is also valid
    a_north_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_in_valid |-> (i_north <= ll2mm_pkg::NORTH_MAX)
                                   && (i_north >= -ll2mm_pkg::NORTH_MAX))
        else $error("north offset out of range");
endmodule

bind latlon_to_local_mm ll2mm_checker u_ll2mm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_north     (o_rsp.north_mm),
    .i_east      (o_rsp.east_mm)
);
